/* sv/cts_pkg.sv */
`default_nettype none
package cts_pkg;
	localparam int NPROC = 16;
	localparam int SW = 4;
	localparam int CW = 5;

	localparam logic [1:0] POL_FIFO = 2'd0;
	localparam logic [1:0] POL_SRT  = 2'd1;
	localparam logic [1:0] POL_RR   = 2'd2;
	localparam logic [1:0] POL_PRI  = 2'd3;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	localparam logic [0:0] REG_POLICY  = 1'd0;
	localparam logic [0:0] REG_QUANTUM = 1'd1;

	typedef struct packed {
		logic load;
		logic any_scan;
		logic compact;
		logic arrive;
		logic pick;
		logic rr_fix;
		logic finish;
		logic done_tick;
	} cts_cmd_t;

	typedef struct packed {
		logic last;
		logic any_burst;
		logic rr_need;
	} cts_stat_t;
endpackage
`default_nettype wire

/* sv/cpu_tick_scheduler.sv */
`default_nettype none
// channel | dir | handshake           | payload
// in      | in  | in_valid/in_stall   | cmd slot_index arrival_time burst_length priority_level
// out     | out | out_valid/out_stall | run_slot cpu_idle all_done tick_time
// cfg     | in  | APB psel/penable    | policy_mode (0x0), time_quantum (0x4)
// A load is written to the slot tables as it is accepted and leaves the block idle.
// A tick holds the input through a burst scan (a done tick ends there), queue
// compaction, an arrival scan, round robin fixup (round robin only), a minimum
// search (shortest remaining and priority; a single pick step otherwise) and a
// result step, and then returns to idle, where it can take the next command.
// Reset clears all slot tables by clearing bursts, arrivals and priorities.
// A result held by out_stall blocks only the end of the next tick; a done tick
// that meets a held result rescans the slots and ends on a later scan.
module cpu_tick_scheduler (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        cmd,
	input  wire logic [3:0]  slot_index,
	input  wire logic [15:0] arrival_time,
	input  wire logic [15:0] burst_length,
	input  wire logic [7:0]  priority_level,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [3:0]       run_slot,
	output logic             cpu_idle,
	output logic             all_done,
	output logic [15:0]      tick_time,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import cts_pkg::*;

	cts_cmd_t  c;
	cts_stat_t s;
	logic res_load;
	logic [1:0] pol_q;
	logic [7:0] tq_q;
	logic busy;

	assign pready = 1'b1;
	assign busy = out_valid && out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pol_q <= POL_FIFO; tq_q <= 8'd1; out_valid <= 1'b0;
		end else begin
			if (psel && penable && pwrite) begin
				// decode the register index from the word address
				if (paddr[2] == REG_POLICY) pol_q <= pwdata[1:0];
				else tq_q <= pwdata[7:0];
			end
			if (res_load) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_QUANTUM) prdata[7:0] = tq_q;
		else prdata[1:0] = pol_q;
	end

	cts_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_cmd(cmd), .in_stall,
		.out_busy(busy), .cmd(c), .st(s), .res_load
	);

	cts_dp u_dp (
		.clk, .arst_n, .cmd(c), .st(s), .slot_index, .arrival_time, .burst_length,
		.priority_level, .policy_mode(pol_q), .time_quantum(tq_q),
		.r_slot(run_slot), .r_idle(cpu_idle), .r_done(all_done), .r_time(tick_time)
	);
endmodule
`default_nettype wire

/* sv/cts_ctrl.sv */
`default_nettype none
module cts_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic              in_cmd,
	output logic                   in_stall,
	input  wire logic              out_busy,
	output cts_pkg::cts_cmd_t      cmd,
	input  wire cts_pkg::cts_stat_t st,
	output logic                   res_load
);
	import cts_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_ANY  = 3'd1;
	localparam logic [2:0] S_CMP  = 3'd2;
	localparam logic [2:0] S_ARR  = 3'd3;
	localparam logic [2:0] S_RR   = 3'd4;
	localparam logic [2:0] S_PICK = 3'd5;
	localparam logic [2:0] S_FIN  = 3'd6;

	logic [2:0] state_q;
	logic go;

	assign in_stall = (state_q != S_IDLE);
	assign go = in_valid && !in_stall;

	always_comb begin
		cmd = '0;
		res_load = 1'b0;
		case (state_q)
			S_IDLE: cmd.load = go && (in_cmd == CMD_LOAD);
			S_ANY: begin
				cmd.any_scan = 1'b1;
				if (st.last && !st.any_burst && !out_busy) begin
					cmd.done_tick = 1'b1;
					res_load = 1'b1;
				end
			end
			S_CMP: cmd.compact = 1'b1;
			S_ARR: cmd.arrive = 1'b1;
			S_RR: cmd.rr_fix = 1'b1;
			S_PICK: cmd.pick = 1'b1;
			S_FIN: if (!out_busy) begin
				cmd.finish = 1'b1;
				res_load = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: if (go && in_cmd == CMD_TICK) state_q <= S_ANY;
				S_ANY: if (st.last) begin
					if (st.any_burst) state_q <= S_CMP;
					else if (!out_busy) state_q <= S_IDLE;
				end
				S_CMP: if (st.last) state_q <= S_ARR;
				S_ARR: if (st.last) state_q <= st.rr_need ? S_RR : S_PICK;
				S_RR: if (st.last) state_q <= S_PICK;
				S_PICK: if (st.last) state_q <= S_FIN;
				S_FIN: if (!out_busy) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

/* sv/cts_dp.sv */
`default_nettype none
module cts_dp (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cts_pkg::cts_cmd_t cmd,
	output cts_pkg::cts_stat_t     st,
	input  wire logic [3:0]        slot_index,
	input  wire logic [15:0]       arrival_time,
	input  wire logic [15:0]       burst_length,
	input  wire logic [7:0]        priority_level,
	input  wire logic [1:0]        policy_mode,
	input  wire logic [7:0]        time_quantum,
	output logic [3:0]             r_slot,
	output logic                   r_idle,
	output logic                   r_done,
	output logic [15:0]            r_time
);
	import cts_pkg::*;

	logic [15:0] burst_q [NPROC];
	logic [15:0] arr_q [NPROC];
	logic [7:0]  pri_q [NPROC];
	logic [SW-1:0] ord_q [NPROC];
	logic [CW-1:0] cnt_q;
	logic [15:0] time_q;
	logic        rrv_q;
	logic [SW-1:0] rrc_q;
	logic [7:0]  rrq_q;

	// shared step counter, reset between phases on last
	logic [CW-1:0] i_q;
	logic [CW-1:0] n_q;
	logic          any_q;
	logic          have_q;
	logic [15:0]   best_q;
	logic [SW-1:0] sel_q;
	// rr fixup: 0 remove, 1 push-back, 2 take front
	logic [1:0]    rph_q;
	logic          rfound_q;
	// finished non-rr pick (sel_q) still waiting to leave the queue
	logic          drop_q;

	logic [SW-1:0] islot;
	logic          qhas;
	logic [SW-1:0] oi;
	logic [15:0]   v;
	logic          rr_expire, rr_gone;
	logic [7:0]    qload;
	logic          keep;

	assign islot = i_q[SW-1:0];
	assign oi = ord_q[islot];
	assign v = (policy_mode == POL_SRT) ? burst_q[oi] : {8'd0, pri_q[oi]};
	assign rr_gone = rrv_q && burst_q[rrc_q] == 16'd0;
	assign rr_expire = rrv_q && rrq_q == 8'd0;
	assign qload = (time_quantum == 8'd0) ? 8'd1 : time_quantum;
	assign keep = burst_q[oi] != 16'd0 && !(drop_q && oi == sel_q);

	always_comb begin
		qhas = 1'b0;
		for (int k = 0; k < NPROC; k++)
			if (CW'(k) < cnt_q && ord_q[k] == islot) qhas = 1'b1;
	end

	always_comb begin
		st.rr_need = (policy_mode == POL_RR);
		st.any_burst = any_q || burst_q[islot] != 16'd0;
		st.last = 1'b0;
		if (cmd.any_scan || cmd.arrive) st.last = (i_q == CW'(NPROC - 1));
		else if (cmd.compact || cmd.pick) st.last = (i_q >= cnt_q);
		else if (cmd.rr_fix) st.last = (rph_q == 2'd2);
		if (cmd.pick && policy_mode != POL_SRT && policy_mode != POL_PRI) st.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NPROC; k++) begin
				burst_q[k] <= '0;
				arr_q[k] <= '0;
				pri_q[k] <= '0;
				ord_q[k] <= '0;
			end
			r_slot <= '0; r_idle <= 1'b0; r_done <= 1'b0; r_time <= '0;
		end else begin
			if (cmd.load) begin
				arr_q[slot_index] <= arrival_time;
				burst_q[slot_index] <= burst_length;
				pri_q[slot_index] <= priority_level;
			end
			if (cmd.compact && i_q < cnt_q && keep)
				ord_q[n_q[SW-1:0]] <= oi;
			if (cmd.arrive && arr_q[islot] == time_q && burst_q[islot] != 16'd0 && !qhas
					&& cnt_q < CW'(NPROC))
				ord_q[cnt_q[SW-1:0]] <= islot;
			// close the gap from the found entry onward
			if (cmd.rr_fix && rph_q == 2'd0 && (rr_gone || rr_expire)
					&& (rfound_q || oi == rrc_q) && i_q + 1'b1 < cnt_q)
				ord_q[islot] <= ord_q[islot + 1'b1];
			if (cmd.rr_fix && rph_q == 2'd1 && rr_expire && !rr_gone)
				ord_q[cnt_q[SW-1:0]] <= rrc_q;
			if (cmd.finish) begin
				r_slot <= have_q ? sel_q : '0;
				r_idle <= !have_q;
				r_done <= 1'b0;
				r_time <= time_q;
				if (have_q && burst_q[sel_q] != 16'd0) burst_q[sel_q] <= burst_q[sel_q] - 1'b1;
			end
			if (cmd.done_tick) begin
				r_slot <= '0;
				r_idle <= 1'b1;
				r_done <= 1'b1;
				r_time <= time_q;
			end
		end
	end

	// a non-rr pick that finishes is flagged here and dropped by the next
	// tick's compaction, before anything else reads the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0; time_q <= '0; rrv_q <= 1'b0; rrc_q <= '0; rrq_q <= '0;
			i_q <= '0; n_q <= '0; any_q <= 1'b0; have_q <= 1'b0; best_q <= '0;
			sel_q <= '0; rph_q <= '0; rfound_q <= 1'b0; drop_q <= 1'b0;
		end else begin
			if (cmd.any_scan) begin
				any_q <= st.any_burst;
				i_q <= st.last ? '0 : i_q + 1'b1;
				n_q <= '0;
			end
			if (cmd.compact) begin
				if (st.last) begin
					cnt_q <= n_q; i_q <= '0; any_q <= 1'b0; drop_q <= 1'b0;
				end else begin
					if (keep) n_q <= n_q + 1'b1;
					i_q <= i_q + 1'b1;
				end
			end
			if (cmd.arrive) begin
				if (arr_q[islot] == time_q && burst_q[islot] != 16'd0 && !qhas
						&& cnt_q < CW'(NPROC))
					cnt_q <= cnt_q + 1'b1;
				i_q <= st.last ? '0 : i_q + 1'b1;
				rph_q <= '0; rfound_q <= 1'b0; have_q <= 1'b0;
			end
			if (cmd.rr_fix) begin
				case (rph_q)
					2'd0: begin
						if (!(rr_gone || rr_expire) || i_q >= cnt_q) begin
							if (rfound_q) cnt_q <= cnt_q - 1'b1;
							rph_q <= 2'd1; i_q <= '0;
						end else begin
							if (oi == rrc_q) rfound_q <= 1'b1;
							i_q <= i_q + 1'b1;
						end
					end
					2'd1: begin
						if (rr_expire && !rr_gone) cnt_q <= cnt_q + 1'b1;
						rph_q <= 2'd2;
					end
					default: begin
						if (!rrv_q || rrq_q == 8'd0 || burst_q[rrc_q] == 16'd0) begin
							if (cnt_q != '0) begin
								rrc_q <= ord_q[0]; rrv_q <= 1'b1; rrq_q <= qload;
							end else rrv_q <= 1'b0;
						end
						rph_q <= '0; rfound_q <= 1'b0;
					end
				endcase
			end
			if (cmd.pick) begin
				case (policy_mode)
					POL_FIFO: begin
						have_q <= cnt_q != '0; sel_q <= ord_q[0]; i_q <= '0;
					end
					POL_RR: begin
						have_q <= rrv_q; sel_q <= rrc_q;
					end
					default: begin
						if (st.last) i_q <= '0;
						else begin
							if (!have_q || v < best_q) begin
								best_q <= v; sel_q <= oi; have_q <= 1'b1;
							end
							i_q <= i_q + 1'b1;
						end
					end
				endcase
				rfound_q <= 1'b0;
			end
			if (cmd.finish) begin
				if (have_q && policy_mode == POL_RR && rrq_q != 8'd0) rrq_q <= rrq_q - 1'b1;
				if (have_q && policy_mode != POL_RR && burst_q[sel_q] <= 16'd1) drop_q <= 1'b1;
				if (time_q != 16'hFFFF) time_q <= time_q + 1'b1;
			end
		end
	end
endmodule
`default_nettype wire
